// ===== rtl/sie_pkg.sv =====
// Shared types and constants for the signed integer extractor.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package sie_pkg;

  // Result codes carried in the kind field
  typedef enum logic [1:0] {
    KIND_NUMBER    = 2'd0,
    KIND_OVERFLOW  = 2'd1,
    KIND_NO_NUMBER = 2'd2
  } kind_e;

  // Character codes the parser reacts to
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

  localparam int unsigned OUT_WIDTH = 64;

  // One input word
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_item_t;

  // Input word held in the input register
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

  // One result word
  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] value;
    kind_e                       kind;
    logic                        end_flag;
  } out_item_t;

  // Result of one parsing step
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } step_res_t;

endpackage

// ===== rtl/sie_if.sv =====
// Valid/ready channel interfaces for characters in and integers out.
// Depends on sie_pkg for the result code type and the output width.
`timescale 1ns / 1ps

interface sie_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface sie_out_if
  import sie_pkg::*;
;
  logic                        valid;
  logic                        ready;
  logic signed [OUT_WIDTH-1:0] value;
  kind_e                       kind;
  logic                        end_flag;

  modport source (output valid, output value, output kind, output end_flag, input ready);
  modport sink   (input valid, input value, input kind, input end_flag, output ready);
endinterface

// ===== rtl/sie_in_reg.sv =====
// Input register: captures one character word per cycle from in_i while ready.
// Depends on sie_pkg and sie_in_if.
`timescale 1ns / 1ps

module sie_in_reg
  import sie_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  sie_in_if.sink     in_i,
  input  logic       advance_i,
  output stage_t     stage_o
);

  logic     valid_q;
  in_item_t item_q;

  // Take a new word when empty or when the held word moves on this cycle
  assign in_i.ready = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.ch   <= in_i.ch;
      item_q.last <= in_i.last;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.item  = item_q;

endmodule

// ===== rtl/sie_step.sv =====
// Parser state and the combinational step logic for one character.
// Depends on sie_pkg.
`timescale 1ns / 1ps

module sie_step
  import sie_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  stage_t    stage_i,
  input  logic      advance_i,
  output step_res_t res_o
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned PW = VALUE_WIDTH + 4;
  localparam logic [W-1:0] NegLimit = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] PosLimit = NegLimit - W'(1);
  localparam logic [W-1:0] SatMag   = NegLimit + W'(1);

  logic [W-1:0] mag_q, mag_d;
  logic         neg_q, neg_d;
  logic         run_q, run_d;
  logic         pmin_q, pmin_d;
  logic         first_q, first_d;
  logic         failed_q, failed_d;

  logic [7:0]          ch;
  logic                last;
  logic                is_digit, is_alpha, is_minus;
  logic [3:0]          digit;
  logic [PW-1:0]       prod;
  logic                sat;
  logic [W-1:0]        mag_a;
  logic                neg_a, run_a;
  logic                emit, no_num, over;
  logic signed [W-1:0] signed_val;

  assign ch       = stage_i.item.ch;
  assign last     = stage_i.item.last;
  assign is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
  assign is_alpha = ((ch >= CHAR_UPPER_A) && (ch <= CHAR_UPPER_Z)) ||
                    ((ch >= CHAR_LOWER_A) && (ch <= CHAR_LOWER_Z));
  assign is_minus = (ch == CHAR_MINUS);
  assign digit    = 4'(ch - CHAR_ZERO);

  // Multiply by ten as two shifts, then add the digit; saturate past the negative limit
  assign prod = (PW'(mag_q) << 3) + (PW'(mag_q) << 1) + PW'(digit);
  assign sat  = prod > PW'(NegLimit);

  always_comb begin
    mag_a    = mag_q;
    neg_a    = neg_q;
    run_a    = run_q;
    emit     = 1'b0;
    no_num   = 1'b0;
    over     = 1'b0;
    mag_d    = mag_q;
    neg_d    = neg_q;
    run_d    = run_q;
    pmin_d   = pmin_q;
    first_d  = first_q;
    failed_d = failed_q;

    if (!failed_q) begin
      // Classify the character and update the run
      priority if (is_digit) begin
        neg_a = neg_q || pmin_q;
        run_a = 1'b1;
        mag_a = sat ? SatMag : prod[W-1:0];
      end else if (first_q) begin
        if (is_minus) begin
          neg_a = 1'b1;
        end
      end else if (is_alpha) begin
        if (run_q) begin
          mag_a = '0;
          neg_a = 1'b0;
          run_a = 1'b0;
        end
      end else if (run_q) begin
        emit = 1'b1;
      end

      // The final character always closes the string
      if (last && !emit) begin
        if (run_a) begin
          emit = 1'b1;
        end else begin
          no_num = 1'b1;
        end
      end

      over = emit && (mag_a > (neg_a ? NegLimit : PosLimit));

      mag_d    = emit ? '0 : mag_a;
      neg_d    = emit ? 1'b0 : neg_a;
      run_d    = emit ? 1'b0 : run_a;
      failed_d = over;
      pmin_d   = is_minus;
      first_d  = 1'b0;
    end

    // Re-arm for the next string
    if (last) begin
      mag_d    = '0;
      neg_d    = 1'b0;
      run_d    = 1'b0;
      pmin_d   = 1'b0;
      first_d  = 1'b1;
      failed_d = 1'b0;
    end
  end

  // Build the result word
  assign signed_val = neg_a ? -mag_a : mag_a;

  always_comb begin
    res_o.valid         = stage_i.valid && (emit || no_num);
    res_o.item.end_flag = last;
    if (no_num) begin
      res_o.item.kind  = KIND_NO_NUMBER;
      res_o.item.value = '0;
    end else if (over) begin
      res_o.item.kind  = KIND_OVERFLOW;
      res_o.item.value = '0;
    end else begin
      res_o.item.kind  = KIND_NUMBER;
      res_o.item.value = OUT_WIDTH'(signed_val);
    end
  end

  // Advance parser state once per word consumed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q    <= '0;
      neg_q    <= 1'b0;
      run_q    <= 1'b0;
      pmin_q   <= 1'b0;
      first_q  <= 1'b1;
      failed_q <= 1'b0;
    end else if (advance_i) begin
      mag_q    <= mag_d;
      neg_q    <= neg_d;
      run_q    <= run_d;
      pmin_q   <= pmin_d;
      first_q  <= first_d;
      failed_q <= failed_d;
    end
  end

endmodule

// ===== rtl/sie_out_reg.sv =====
// Output register: holds one result word until the receiver takes it.
// Depends on sie_pkg and sie_out_if.
`timescale 1ns / 1ps

module sie_out_reg
  import sie_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  step_res_t  res_i,
  input  logic       advance_i,
  output logic       free_o,
  sie_out_if.source  out_o
);

  logic      valid_q;
  out_item_t item_q;

  // Room for a new word when empty or when the held word is taken now
  assign free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= res_i.valid;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && res_i.valid) begin
      item_q <= res_i.item;
    end
  end

  assign out_o.valid    = valid_q;
  assign out_o.value    = item_q.value;
  assign out_o.kind     = item_q.kind;
  assign out_o.end_flag = item_q.end_flag;

endmodule

// ===== rtl/signed_integer_extractor_unit.sv =====
// Top level of the signed integer extractor: input register, step logic, output register.
// Depends on sie_pkg, sie_if, sie_in_reg, sie_step and sie_out_reg.
`timescale 1ns / 1ps

// Usage
//   in_i takes one ASCII character word per cycle while ready (ch, last); last marks the
//   final character of a string. out_o gives at most one result word per
//   character: value (64-bit signed, sign-extended from VALUE_WIDTH bits),
//   kind (number, overflow, end of string without number) and end_flag.
//   Every string yields exactly one word with end_flag set, except a string
//   that already reported an overflow, which then yields nothing more.
//   Throughput: one character per cycle while out_o is not stalled. The whole
//   step (multiply by ten as shift-and-add, range check, negate) sits between
//   the input register and the output register.
//   Path: an accepted character is held in the input register, and its result
//   is registered in the output register and shown on out_o from there.
//   Reset: asynchronous, active low; empties both registers and returns the
//   parser to the start of a string. No clearing pass is needed.
//   Stall: while out_o holds a word that is not taken, the input register
//   holds its character and in_i drops ready once that register is full.
module signed_integer_extractor_unit
  import sie_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sie_in_if.sink    in_i,
  sie_out_if.source out_o
);

  stage_t    stage;
  step_res_t res;
  logic      out_free;
  logic      advance;

  // Move the held character through the step when the output can take it
  assign advance = stage.valid && out_free;

  sie_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .stage_o   (stage)
  );

  sie_step #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .stage_i   (stage),
    .advance_i (advance),
    .res_o     (res)
  );

  sie_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .res_i     (res),
    .advance_i (advance),
    .free_o    (out_free),
    .out_o     (out_o)
  );

endmodule

// ===== rtl/sie_checker.sv =====
// Port-level checks for the signed integer extractor, bound to the top level.
// Depends on sie_pkg and signed_integer_extractor_unit.
`timescale 1ns / 1ps

module sie_checker
  import sie_pkg::*;
(
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic signed [OUT_WIDTH-1:0] out_value_i,
  input kind_e                       out_kind_i,
  input logic                        out_end_flag_i
);

  // Hold a stalled result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i) &&
                                    $stable(out_kind_i) && $stable(out_end_flag_i))
    else $error("stalled result word changed");

  // Error and no-number words carry a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == KIND_OVERFLOW || out_kind_i == KIND_NO_NUMBER)
      |-> out_value_i == '0)
    else $error("non-number result carries a value");

  // A no-number word is only produced by the final character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == KIND_NO_NUMBER |-> out_end_flag_i)
    else $error("no-number result without end flag");

  // Nothing is shown the cycle after reset releases
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result word present right after reset");

endmodule

bind signed_integer_extractor_unit sie_checker u_sie_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_value_i    (out_o.value),
  .out_kind_i     (out_o.kind),
  .out_end_flag_i (out_o.end_flag)
);

// ===== tb/signed_integer_extractor_unit_test.sv =====
// Self-checking testbench for signed_integer_extractor_unit: a character stream goes in, and
// every result word is compared with a cycle-free predictor of the parser.
// Depends on sie_pkg, sie_if and the RTL of the unit.
`timescale 1ns / 1ps

module signed_integer_extractor_unit_test;
  import sie_pkg::*;

  localparam int unsigned VALUE_W = 64;
  localparam logic [63:0] NEG_LIM = 64'd1 << (VALUE_W - 1);
  localparam logic [63:0] POS_LIM = NEG_LIM - 64'd1;
  localparam logic [63:0] SAT_MAG = NEG_LIM + 64'd1;
  localparam logic [7:0]  SEP_SPACE = 8'h20;
  localparam logic [7:0]  SEP_COMMA = 8'h2C;
  localparam int          PHASE_CHARS = 425;
  localparam int          HOLD_CYCLES = 250;

  logic clk_i = 1'b0;
  logic rst_ni;

  sie_in_if  in_bus ();
  sie_out_if out_bus ();

  signed_integer_extractor_unit #(
    .VALUE_WIDTH(VALUE_W)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  always #5ns clk_i = ~clk_i;

  // Characters waiting to be sent and results still owed by the unit
  in_item_t  text_q[$];
  out_item_t pending_results[$];
  in_item_t  next_word;
  out_item_t want;

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int mismatch_cnt = 0;
  logic hold_go = 1'b0;
  logic hold_used;
  int hold_cnt;

  // Parser state as the predictor sees it
  logic [63:0] run_mag = '0;
  logic        run_neg = 1'b0;
  logic        run_on = 1'b0;
  logic        prev_minus = 1'b0;
  logic        first_char = 1'b1;
  logic        str_failed = 1'b0;

  function automatic logic char_digit(input logic [7:0] c);
    return c >= CHAR_ZERO && c <= CHAR_NINE;
  endfunction

  function automatic logic char_letter(input logic [7:0] c);
    return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) || (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z);
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= 100) $display("%0t mismatch: %s", $time, what);
  endtask

  task automatic clear_run();
    run_mag = '0;
    run_neg = 1'b0;
    run_on = 1'b0;
  endtask

  task automatic restart_string();
    clear_run();
    prev_minus = 1'b0;
    first_char = 1'b1;
    str_failed = 1'b0;
  endtask

  task automatic push_result(input logic [63:0] v, input kind_e k, input logic fin);
    out_item_t r;
    r.value = v;
    r.kind = k;
    r.end_flag = fin;
    pending_results = {pending_results, r};
  endtask

  // Close the run: a number if it fits its sign's range, else an overflow
  task automatic close_run(input logic fin);
    if (run_mag > (run_neg ? NEG_LIM : POS_LIM)) begin
      push_result('0, KIND_OVERFLOW, fin);
      str_failed = 1'b1;
    end else begin
      push_result(run_neg ? 64'd0 - run_mag : run_mag, KIND_NUMBER, fin);
    end
    clear_run();
  endtask

  // Advance the parser by one accepted character
  task automatic parse_char(input logic [7:0] c, input logic fin);
    logic [63:0] d;
    logic emitted;
    emitted = 1'b0;
    if (!str_failed) begin
      if (char_digit(c)) begin
        d = 64'(c - CHAR_ZERO);
        if (prev_minus) run_neg = 1'b1;
        run_on = 1'b1;
        if (run_mag > (NEG_LIM - d) / 64'd10) run_mag = SAT_MAG;
        else run_mag = run_mag * 64'd10 + d;
      end else if (first_char) begin
        if (c == CHAR_MINUS) run_neg = 1'b1;
      end else if (char_letter(c)) begin
        if (run_on) clear_run();
      end else if (run_on) begin
        close_run(fin);
        emitted = 1'b1;
      end
      if (fin && !emitted) begin
        if (run_on) close_run(1'b1);
        else push_result('0, KIND_NO_NUMBER, 1'b1);
      end
      prev_minus = (c == CHAR_MINUS);
      first_char = 1'b0;
    end
    if (fin) restart_string();
  endtask

  // Driver: predict on acceptance, then offer the next word or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      in_bus.ch <= '0;
      in_bus.last <= 1'b0;
      restart_string();
    end else begin
      if (in_bus.valid && in_bus.ready) parse_char(in_bus.ch, in_bus.last);
      if (!in_bus.valid || in_bus.ready) begin
        if (text_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          next_word = text_q.pop_front();
          in_bus.valid <= 1'b1;
          in_bus.ch <= next_word.ch;
          in_bus.last <= next_word.last;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted down once when requested
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt <= 0;
      hold_used <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (hold_go && !hold_used) begin
      hold_cnt <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end
  end

  // Monitor: check each taken result word against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected word value=%0d kind=%0d end=%0b",
                                    out_bus.value, out_bus.kind, out_bus.end_flag));
        end else begin
          want = pending_results.pop_front();
          if (out_bus.value !== want.value)
            report_mismatch($sformatf("value %0d, want %0d", out_bus.value, want.value));
          if (out_bus.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", out_bus.kind, want.kind));
          if (out_bus.end_flag !== want.end_flag)
            report_mismatch($sformatf("end_flag %0b, want %0b", out_bus.end_flag,
                                      want.end_flag));
        end
      end
      out_bus.ready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  task automatic push_char(input logic [7:0] c);
    in_item_t w;
    w.ch = c;
    w.last = 1'b0;
    text_q = {text_q, w};
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  // Mark the most recent character as the end of its string
  task automatic end_string();
    in_item_t w;
    w = text_q.pop_back();
    w.last = 1'b1;
    text_q = {text_q, w};
  endtask

  function automatic logic [7:0] other_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (char_digit(c) || char_letter(c));
    return c;
  endfunction

  // One random string: mostly signed numbers between separators, some raw noise
  task automatic add_random_string();
    int n_tok;
    int sel;
    logic [63:0] m;
    if ($urandom_range(0, 9) == 0) begin
      n_tok = $urandom_range(1, 16);
      repeat (n_tok) push_char(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 2) == 0) push_char(CHAR_MINUS);
      n_tok = $urandom_range(1, 4);
      repeat (n_tok) begin
        sel = $urandom_range(0, 9);
        if (sel <= 3) begin
          push_text($sformatf("%0d", $urandom_range(0, sel == 0 ? 9 : 99999)));
        end else if (sel <= 5) begin
          // values at the edges of both signed ranges
          case ($urandom_range(0, 6))
            0: m = POS_LIM - 64'd1;
            1: m = POS_LIM;
            2: m = NEG_LIM;
            3: m = NEG_LIM + 64'd1;
            4: m = '1;
            5: m = POS_LIM / 64'd10;
            default: m = 64'd0;
          endcase
          if ($urandom_range(0, 1) == 1) push_char(CHAR_MINUS);
          if ($urandom_range(0, 3) == 0) push_text("00");
          push_text($sformatf("%0d", m));
        end else if (sel == 6) begin
          m = {$urandom, $urandom};
          push_text($sformatf("%0d", m >> $urandom_range(0, 63)));
        end else if (sel == 7) begin
          repeat ($urandom_range(20, 24)) push_char(CHAR_ZERO + 8'($urandom_range(0, 9)));
        end else if (sel == 8) begin
          repeat ($urandom_range(1, 3))
            push_char($urandom_range(0, 1) ? CHAR_UPPER_A + 8'($urandom_range(0, 25))
                                           : CHAR_LOWER_A + 8'($urandom_range(0, 25)));
        end else begin
          push_char(other_char());
        end
        case ($urandom_range(0, 5))
          0: push_char(CHAR_MINUS);
          1: push_char(SEP_SPACE);
          2: push_char(SEP_COMMA);
          3: push_char(other_char());
          default: ;
        endcase
      end
    end
    end_string();
  endtask

  initial begin
    int target;
    rst_ni = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.ch = '0;
    in_bus.last = 1'b0;
    out_bus.ready = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int phase = 0; phase < 4; phase++) begin
      @(negedge clk_i);
      case (phase)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 52; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 52; end
        default: begin src_idle_pct = 10; snk_stall_pct = 10; end
      endcase
      if (phase == 0) begin
        // leading minus, sign kept across a letter, letter drops a run,
        // minus right before a digit, high bytes, string end cases, overflow
        push_text("-7");
        end_string();
        push_text("-a3");
        end_string();
        push_text("12b4-5");
        end_string();
        push_char(8'h80);
        push_char(8'hFF);
        push_char(CHAR_ZERO);
        end_string();
        push_text("Z9z");
        end_string();
        push_text("1 ");
        end_string();
        push_text("-9223372036854775809,7");
        end_string();
      end
      target = text_q.size() + PHASE_CHARS;
      while (text_q.size() < target) add_random_string();
      // stall the receiver while the sender keeps the input full
      if (phase == 0) hold_go = 1'b1;
      // wait until every character is sent and every owed result has come out
      while (text_q.size() != 0 || in_bus.valid || pending_results.size() != 0)
        @(negedge clk_i);
    end

    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("[signed_integer_extractor_unit] OK");
    end else begin
      $display("[signed_integer_extractor_unit] ERROR");
    end
    $finish;
  end

  // Hard stop if the unit hangs
  initial begin
    #2ms;
    $display("[signed_integer_extractor_unit] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sie_pkg.sv
rtl/sie_if.sv
rtl/sie_in_reg.sv
rtl/sie_step.sv
rtl/sie_out_reg.sv
rtl/signed_integer_extractor_unit.sv
rtl/sie_checker.sv
tb/signed_integer_extractor_unit_test.sv
